[design/lottery_task_scheduler_assert.svh]
// Assertion macros used by the lottery task scheduler port checker
`ifndef LOTTERY_TASK_SCHEDULER_ASSERT_SVH
`define LOTTERY_TASK_SCHEDULER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define LTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/lts_pkg.sv]
// Shared types and codes for the lottery task scheduler
package lts_pkg;

  localparam int PRIO_W = 7;
  localparam int FRAC_W = 16;
  localparam logic [PRIO_W-1:0] MAX_PRIO = 7'd100;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_BLOCKED = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_KILL   = 2'd1,
    MODE_SCHED  = 2'd2,
    MODE_BLOCK  = 2'd3
  } mode_t;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_FULL    = 2'd1;
  localparam logic [1:0] ERR_NO_TASK = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_RD,
    ST_C_CHK,
    ST_C_PAR,
    ST_C_WPAR,
    ST_K_RD,
    ST_K_CHK,
    ST_K_PCHK,
    ST_K_FREE,
    ST_S_RD,
    ST_S_ACC,
    ST_S_MUL,
    ST_S_PRD,
    ST_S_PCHK,
    ST_RESP
  } fsm_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

[design/lottery_task_scheduler.sv]
// Lottery task scheduler top level: slot table sequencer and result register
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | mode, priority_req, block_parent, target, fraction
//   out_    | output    | out_valid/out_stall | error, task_index, active_task
//
// One item at a time through the single slot table port, a read and a check per slot visit.
// Create scans for a free slot and may link a parent; block reads and rewrites the target;
// kill walks the child chain; schedule runs a sum pass, a multiply and a pick pass.
// Reset clears the table at once through per-slot written flags, no sweep.
// A waiting result does not stop the next item; a stalled result holds the last state.
module lottery_task_scheduler
  import lts_pkg::*;
#(
  parameter int TASK_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic signed [7:0] in_priority_req,
  input  logic              in_block_parent,
  input  logic [3:0]        in_target_task,
  input  logic [15:0]       in_random_fraction,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_error,
  output logic [3:0]        out_task_index,
  output logic [3:0]        out_active_task
);

  localparam int SW    = $clog2(TASK_SLOTS);
  localparam int LW    = SW + 1;
  localparam int SUM_W = $clog2(TASK_SLOTS * 100 + 1);
  localparam int MUL_W = FRAC_W + SUM_W;
  localparam int EW    = 2 + PRIO_W + 2 * LW;
  localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);

  typedef struct packed {
    logic [1:0]        st;
    logic [PRIO_W-1:0] prio;
    logic [LW-1:0]     par;
    logic [LW-1:0]     chd;
  } entry_t;

  fsm_t state_r, state_nxt;

  mode_t             mode_r, mode_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              link_r, link_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [SW-1:0]     cnt_r, cnt_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [SW-1:0]     t_r, t_nxt;
  logic [SW-1:0]     steps_r, steps_nxt;
  logic              first_r, first_nxt;
  logic [LW-1:0]     cl_r, cl_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  cum_r, cum_nxt;
  logic [MUL_W-1:0]  lhs_r, lhs_nxt;
  entry_t            ent_r, ent_nxt;
  logic [SW-1:0]     cur_r, cur_nxt;
  logic [1:0]        err_r, err_nxt;
  logic [SW-1:0]     idx_r, idx_nxt;

  logic              out_valid_r;
  logic [1:0]        out_error_r;
  logic [3:0]        out_index_r;
  logic [3:0]        out_active_r;

  mem_ctl_t          mctl;
  logic [SW-1:0]     maddr;
  entry_t            wd;
  logic [EW-1:0]     rdata;
  logic              rvalid;
  entry_t            rd;
  logic              occ;
  logic              ready;

  logic [6:0]        tgt_w;
  logic              tgt_ok;
  logic [PRIO_W-1:0] prio_clamp;
  logic [SUM_W-1:0]  cum_add;
  logic              win;
  logic              accept;
  logic              load_out;

  lts_mem #(
    .DEPTH (TASK_SLOTS),
    .DW    (EW)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mctl),
    .addr   (maddr),
    .wdata  (wd),
    .rdata  (rdata),
    .rvalid (rvalid)
  );

  assign rd    = entry_t'(rdata);
  assign occ   = rvalid && (rd.st != SLOT_FREE);
  assign ready = rvalid && (rd.st == SLOT_READY);

  assign tgt_w  = 7'(in_target_task);
  assign tgt_ok = tgt_w < 7'(TASK_SLOTS);

  always_comb begin
    if (in_priority_req < 8'sd0) begin
      prio_clamp = '0;
    end else if (in_priority_req > 8'sd100) begin
      prio_clamp = MAX_PRIO;
    end else begin
      prio_clamp = in_priority_req[PRIO_W-1:0];
    end
  end

  assign cum_add  = cum_r + SUM_W'(rd.prio);
  // winner once the running sum scaled by 2^16 passes fraction times total
  assign win      = ready && ({cum_add, 16'b0} > lhs_r);
  assign accept   = (state_r == ST_IDLE) && in_valid;
  assign load_out = (state_r == ST_RESP) && (!out_valid_r || !out_stall);
  assign in_stall = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_CREATE: state_nxt = ST_C_RD;
            MODE_SCHED:  state_nxt = ST_S_RD;
            default:     state_nxt = tgt_ok ? ST_K_RD : ST_RESP;
          endcase
        end
      end
      ST_C_RD:  state_nxt = ST_C_CHK;
      ST_C_CHK: begin
        if (!occ) begin
          state_nxt = link_r ? ST_C_PAR : ST_RESP;
        end else if (cnt_r == LAST) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_C_RD;
        end
      end
      ST_C_PAR:  state_nxt = occ ? ST_C_WPAR : ST_RESP;
      ST_C_WPAR: state_nxt = ST_RESP;
      ST_K_RD:   state_nxt = ST_K_CHK;
      ST_K_CHK: begin
        if (!occ || mode_r == MODE_BLOCK) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = rd.par[SW] ? ST_K_PCHK : ST_K_FREE;
        end
      end
      ST_K_PCHK: state_nxt = ST_K_FREE;
      ST_K_FREE: state_nxt = (cl_r[SW] && steps_r != LAST) ? ST_K_RD : ST_RESP;
      ST_S_RD:   state_nxt = ST_S_ACC;
      ST_S_ACC:  state_nxt = (cnt_r == LAST) ? ST_S_MUL : ST_S_RD;
      ST_S_MUL:  state_nxt = (sum_r == '0) ? ST_RESP : ST_S_PRD;
      ST_S_PRD:  state_nxt = ST_S_PCHK;
      ST_S_PCHK: begin
        if (win || cnt_r == LAST) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_S_PRD;
        end
      end
      ST_RESP:   state_nxt = load_out ? ST_IDLE : ST_RESP;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // table accesses and working registers
  always_comb begin
    mctl      = '0;
    maddr     = '0;
    wd        = '0;
    mode_nxt  = mode_r;
    prio_nxt  = prio_r;
    link_nxt  = link_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    t_nxt     = t_r;
    steps_nxt = steps_r;
    first_nxt = first_r;
    cl_nxt    = cl_r;
    sum_nxt   = sum_r;
    cum_nxt   = cum_r;
    lhs_nxt   = lhs_r;
    ent_nxt   = ent_r;
    cur_nxt   = cur_r;
    err_nxt   = err_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt  = mode_t'(in_mode);
          prio_nxt  = prio_clamp;
          link_nxt  = in_block_parent;
          frac_nxt  = in_random_fraction;
          t_nxt     = tgt_w[SW-1:0];
          cnt_nxt   = '0;
          steps_nxt = '0;
          first_nxt = 1'b1;
          sum_nxt   = '0;
          idx_nxt   = '0;
          err_nxt   = (mode_t'(in_mode) == MODE_KILL || mode_t'(in_mode) == MODE_BLOCK)
                      && !tgt_ok ? ERR_NO_TASK : ERR_OK;
        end
      end
      ST_C_RD: begin
        mctl.rd = 1'b1;
        maddr   = cnt_r;
      end
      ST_C_CHK: begin
        if (!occ) begin
          slot_nxt = cnt_r;
          idx_nxt  = cnt_r;
          if (link_r) begin
            mctl.rd = 1'b1;
            maddr   = cur_r;
          end else begin
            mctl.wr = 1'b1;
            maddr   = cnt_r;
            wd      = '{st: SLOT_READY, prio: prio_r, par: '0, chd: '0};
          end
        end else if (cnt_r == LAST) begin
          err_nxt = ERR_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_C_PAR: begin
        mctl.wr = 1'b1;
        maddr   = slot_r;
        wd      = '{st: SLOT_READY, prio: prio_r,
                    par: occ ? {1'b1, cur_r} : '0, chd: '0};
        ent_nxt = rd;
      end
      ST_C_WPAR: begin
        mctl.wr = 1'b1;
        maddr   = cur_r;
        wd      = ent_r;
        wd.chd  = {1'b1, slot_r};
      end
      ST_K_RD: begin
        mctl.rd = 1'b1;
        maddr   = t_r;
      end
      ST_K_CHK: begin
        if (!occ) begin
          if (first_r) begin
            err_nxt = ERR_NO_TASK;
          end
        end else if (mode_r == MODE_BLOCK) begin
          mctl.wr = 1'b1;
          maddr   = t_r;
          wd      = rd;
          wd.st   = SLOT_BLOCKED;
        end else begin
          if (first_r) begin
            idx_nxt = t_r;
          end
          cl_nxt = rd.chd;
          if (rd.par[SW]) begin
            mctl.rd = 1'b1;
            maddr   = rd.par[SW-1:0];
          end
        end
      end
      ST_K_PCHK: begin
        // parent entry arrives here; release it and drop its link to us
        if (occ) begin
          mctl.wr = 1'b1;
          maddr   = ent_r.par[SW-1:0];
          wd      = rd;
          if (rd.st == SLOT_BLOCKED) begin
            wd.st = SLOT_READY;
          end
          if (rd.chd[SW] && rd.chd[SW-1:0] == t_r) begin
            wd.chd = '0;
          end
        end
      end
      ST_K_FREE: begin
        mctl.wr = 1'b1;
        maddr   = t_r;
        wd      = '{st: SLOT_FREE, prio: '0, par: '0, chd: '0};
        if (cl_r[SW] && steps_r != LAST) begin
          t_nxt     = cl_r[SW-1:0];
          steps_nxt = steps_r + 1'b1;
          first_nxt = 1'b0;
        end
      end
      ST_S_RD: begin
        mctl.rd = 1'b1;
        maddr   = cnt_r;
      end
      ST_S_ACC: begin
        if (ready) begin
          sum_nxt = sum_r + SUM_W'(rd.prio);
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_S_MUL: begin
        lhs_nxt = MUL_W'(frac_r) * MUL_W'(sum_r);
        cnt_nxt = '0;
        cum_nxt = '0;
      end
      ST_S_PRD: begin
        mctl.rd = 1'b1;
        maddr   = cnt_r;
      end
      ST_S_PCHK: begin
        if (ready) begin
          cum_nxt = cum_add;
        end
        if (win) begin
          cur_nxt = cnt_r;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
    // keep the child entry: the parent's address is needed in the cycle after it arrives
    if (state_r == ST_K_CHK) begin
      ent_nxt = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    prio_r  <= prio_nxt;
    link_r  <= link_nxt;
    frac_r  <= frac_nxt;
    cnt_r   <= cnt_nxt;
    slot_r  <= slot_nxt;
    t_r     <= t_nxt;
    steps_r <= steps_nxt;
    first_r <= first_nxt;
    cl_r    <= cl_nxt;
    sum_r   <= sum_nxt;
    cum_r   <= cum_nxt;
    lhs_r   <= lhs_nxt;
    ent_r   <= ent_nxt;
    err_r   <= err_nxt;
    idx_r   <= idx_nxt;
    if (load_out) begin
      out_error_r  <= err_r;
      out_index_r  <= 4'(idx_r);
      out_active_r <= 4'(cur_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_error       = out_error_r;
  assign out_task_index  = out_index_r;
  assign out_active_task = out_active_r;

endmodule

[design/lts_mem.sv]
// Slot table memory: one port, registered read, per-entry written flags
module lts_mem
  import lts_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int DW    = 20,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata,
  output logic          rvalid
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DW-1:0]    rdata_r;
  logic [DEPTH-1:0] wrt_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r <= mem[addr];
    end
  end

  // an entry never written reads back as a free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrt_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (ctl.wr) begin
        wrt_r[addr] <= 1'b1;
      end
      if (ctl.rd) begin
        rvld_r <= wrt_r[addr];
      end
    end
  end

  assign rdata  = rdata_r;
  assign rvalid = rvld_r;

endmodule

[design/lts_checker.sv]
// Port-level checker for the lottery task scheduler, bound to the top level
`include "lottery_task_scheduler_assert.svh"

module lts_checker
  import lts_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        in_mode,
  input logic signed [7:0] in_priority_req,
  input logic              in_block_parent,
  input logic [3:0]        in_target_task,
  input logic [15:0]       in_random_fraction,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_error,
  input logic [3:0]        out_task_index,
  input logic [3:0]        out_active_task
);

  // one item at a time: an accepted item keeps the input side busy
  `LTS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept not followed by busy")

  `LTS_ASSERT_SAME(a_err_code, out_valid, out_error == ERR_OK || out_error == ERR_FULL || out_error == ERR_NO_TASK, "bad error code")

  // a failed item names no slot
  `LTS_ASSERT_SAME(a_err_no_index, out_valid && out_error != ERR_OK, out_task_index == 4'd0, "index set on error")

  `LTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_error) && $stable(out_task_index) && $stable(out_active_task), "stalled item changed")

endmodule

bind lottery_task_scheduler lts_checker u_lts_checker (.*);

[dv/lottery_task_scheduler_chk.sv]
// Checker for the lottery task scheduler: predicts each result item and compares it
module lottery_task_scheduler_chk
  import lts_pkg::*;
#(
  parameter int TASK_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic signed [7:0] in_priority_req,
  input  logic              in_block_parent,
  input  logic [3:0]        in_target_task,
  input  logic [15:0]       in_random_fraction,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_error,
  input  logic [3:0]        out_task_index,
  input  logic [3:0]        out_active_task,
  output int                fail_count,
  output int                pending,
  output int                sched_moves
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] error;
    logic [3:0] task_index;
    logic [3:0] active_task;
  } sched_result_t;

  slot_st_t    tbl_status [TASK_SLOTS];
  logic [6:0]  tbl_prio   [TASK_SLOTS];
  logic        par_ok     [TASK_SLOTS];
  logic [3:0]  par_idx    [TASK_SLOTS];
  logic        chd_ok     [TASK_SLOTS];
  logic [3:0]  chd_idx    [TASK_SLOTS];
  logic [3:0]  running;
  sched_result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic bit is_live(int s);
    return s < TASK_SLOTS && tbl_status[s] != SLOT_FREE;
  endfunction

  task automatic free_chain(int t);
    int p;
    int n;
    for (int k = 0; k < TASK_SLOTS; k++) begin
      if (par_ok[t]) begin
        p = par_idx[t];
        if (is_live(p)) begin
          if (tbl_status[p] == SLOT_BLOCKED) tbl_status[p] = SLOT_READY;
          if (chd_ok[p] && chd_idx[p] == t) chd_ok[p] = 1'b0;
        end
      end
      n = chd_idx[t];
      tbl_status[t] = SLOT_FREE;
      par_ok[t] = 1'b0;
      if (!chd_ok[t]) return;
      chd_ok[t] = 1'b0;
      if (!is_live(n)) return;
      t = n;
    end
  endtask

  task automatic predict_item(logic [1:0] md, logic signed [7:0] pr, logic bp,
                              logic [3:0] tg, logic [15:0] rf);
    sched_result_t res;
    int slot;
    int prio;
    longint sum;
    longint cum;
    res = '0;
    slot = -1;
    case (mode_t'(md))
      MODE_CREATE: begin
        for (int i = 0; i < TASK_SLOTS; i++)
          if (slot < 0 && tbl_status[i] == SLOT_FREE) slot = i;
        if (slot < 0) begin
          res.error = ERR_FULL;
        end else begin
          prio = pr;
          if (prio < 0) prio = 0;
          if (prio > MAX_PRIO) prio = MAX_PRIO;
          tbl_status[slot] = SLOT_READY;
          tbl_prio[slot] = prio[6:0];
          par_ok[slot] = 1'b0;
          chd_ok[slot] = 1'b0;
          if (bp && is_live(running)) begin
            par_ok[slot] = 1'b1;
            par_idx[slot] = running;
            chd_ok[running] = 1'b1;
            chd_idx[running] = slot[3:0];
          end
          res.task_index = slot[3:0];
        end
      end
      MODE_KILL, MODE_BLOCK: begin
        if (!is_live(tg)) res.error = ERR_NO_TASK;
        else if (md == MODE_KILL) begin
          free_chain(tg);
          res.task_index = tg;
        end else tbl_status[tg] = SLOT_BLOCKED;
      end
      default: begin
        sum = 0;
        cum = 0;
        for (int i = 0; i < TASK_SLOTS; i++)
          if (tbl_status[i] == SLOT_READY) sum += tbl_prio[i];
        if (sum != 0) begin
          for (int i = 0; i < TASK_SLOTS; i++) begin
            if (tbl_status[i] == SLOT_READY) begin
              cum += tbl_prio[i];
              if (cum * 65536 > longint'(rf) * sum) begin
                if (running != i) sched_moves++;
                running = 4'(i);
                break;
              end
            end
          end
        end
      end
    endcase
    res.active_task = running;
    expected_q.push_back(res);
  endtask

  always @(posedge clk) begin
    sched_result_t exp_res;
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        tbl_status[i] = SLOT_FREE;
        par_ok[i] = 1'b0;
        chd_ok[i] = 1'b0;
      end
      running = '0;
      expected_q.delete();
      fail_count = 0;
      sched_moves = 0;
    end else begin
      if (in_valid && !in_stall)
        predict_item(in_mode, in_priority_req, in_block_parent, in_target_task,
                     in_random_fraction);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_error !== exp_res.error) begin
            $error("error: expected %0d got %0d", exp_res.error, out_error);
            fail_count++;
          end
          if (out_task_index !== exp_res.task_index) begin
            $error("task_index: expected %0d got %0d", exp_res.task_index, out_task_index);
            fail_count++;
          end
          if (out_active_task !== exp_res.active_task) begin
            $error("active_task: expected %0d got %0d", exp_res.active_task,
                   out_active_task);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

[dv/lottery_task_scheduler_tb.sv]
// Testbench top for the lottery task scheduler: stimulus, idling and verdict
module lottery_task_scheduler_tb;
  import lts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_mode;
  logic signed [7:0] in_priority_req;
  logic              in_block_parent;
  logic [3:0]        in_target_task;
  logic [15:0]       in_random_fraction;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_error;
  logic [3:0]        out_task_index;
  logic [3:0]        out_active_task;
  int                fail_count;
  int                pending;
  int                sched_moves;
  int                cycles = 0;
  int                items_sent;
  bit                calm;

  lottery_task_scheduler u_top (.*);
  lottery_task_scheduler_chk u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lottery_task_scheduler: mismatch");
      $finish;
    end
  end

  // receiver stall: random hold-offs per item, with calm stretches
  initial begin
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        int w;
        w = $urandom_range(0, 12);
        if (w != 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk iff out_valid);
      end
    end
  end

  task automatic send_item(logic [1:0] md, logic signed [7:0] pr, logic bp,
                           logic [3:0] tg, logic [15:0] rf);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= md;
    in_priority_req <= pr;
    in_block_parent <= bp;
    in_target_task <= tg;
    in_random_fraction <= rf;
    @(posedge clk iff !in_stall);
    items_sent++;
  endtask

  task automatic send_random_item();
    int pick;
    logic [1:0] md;
    pick = $urandom_range(0, 99);
    // creates dominate so the table fills and chains build up
    if (pick < 40) md = MODE_CREATE;
    else if (pick < 60) md = MODE_KILL;
    else if (pick < 85) md = MODE_SCHED;
    else md = MODE_BLOCK;
    send_item(md, 8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100)),
              1'($urandom_range(0, 1)), 4'($urandom), 16'($urandom));
  endtask

  initial begin
    items_sent = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_CREATE;
    in_priority_req = '0;
    in_block_parent = 1'b0;
    in_target_task = '0;
    in_random_fraction = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, clamps, chains, full table, blocked parents
    send_item(MODE_SCHED, 8'sd0, 1'b0, 4'd0, 16'hFFFF);
    send_item(MODE_KILL, 8'sd0, 1'b0, 4'd3, 16'h0);
    send_item(MODE_BLOCK, 8'sd0, 1'b0, 4'd15, 16'h0);
    send_item(MODE_CREATE, -8'sd128, 1'b1, 4'd0, 16'h0);
    send_item(MODE_SCHED, 8'sd0, 1'b0, 4'd0, 16'h8000);
    send_item(MODE_CREATE, 8'sd127, 1'b1, 4'd0, 16'h0);
    send_item(MODE_CREATE, 8'sd100, 1'b1, 4'd0, 16'h0);
    send_item(MODE_CREATE, 8'sd1, 1'b0, 4'd0, 16'h0);
    send_item(MODE_SCHED, 8'sd0, 1'b0, 4'd0, 16'h0000);
    send_item(MODE_SCHED, 8'sd0, 1'b0, 4'd0, 16'hFFFF);
    send_item(MODE_BLOCK, 8'sd0, 1'b0, 4'd0, 16'h0);
    send_item(MODE_KILL, 8'sd0, 1'b0, 4'd1, 16'h0);
    for (int i = 0; i < 17; i++)
      send_item(MODE_CREATE, 8'(i * 7), 1'(i), 4'd0, 16'h0);
    send_item(MODE_SCHED, 8'sd0, 1'b0, 4'd0, 16'h7FFF);
    send_item(MODE_KILL, 8'sd0, 1'b0, 4'd0, 16'h0);

    for (int n = 0; n < 400; n++) begin
      if (n % 100 == 50) calm = 1'b1;
      if (n % 100 == 70) calm = 1'b0;
      send_random_item();
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d items sent, %0d schedule draws moved the active task",
             items_sent, sched_moves);
    if (fail_count == 0) $display("lottery_task_scheduler: match");
    else $display("lottery_task_scheduler: mismatch");
    $finish;
  end
endmodule
